### src/mdio_pkg.sv
// shared types and constants for the mdio management frame master
package mdio_pkg;

  localparam int unsigned PreLenW  = 6;
  localparam int unsigned TaW      = 2;
  localparam int unsigned CntW     = 6;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 16;
  localparam int unsigned ShiftW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 24;

  localparam logic [PreLenW-1:0] PreLenReset = 6'd32;
  localparam logic [TaW-1:0]     TaReset     = 2'd1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PREAMBLE_LENGTH = 2'd0,
    CFG_READ_TURNAROUND = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] phy_addr;
    logic [AddrW-1:0] reg_addr;
    logic [DataW-1:0] write_data;
    logic             mdi_sample;
  } in_item_t;

  typedef struct packed {
    logic             mdc_level;
    logic             mdo_level;
    logic             input_mode;
    logic             busy_res;
    logic             done_res;
    logic [DataW-1:0] read_data;
  } res_t;

endpackage

### src/mdio_frame_core.sv
// frame sequencer: phase, counters, shift registers and line levels
module mdio_frame_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  mdio_pkg::in_item_t            item,
  input  logic [mdio_pkg::PreLenW-1:0]  preamble_length,
  input  logic [mdio_pkg::TaW-1:0]      read_turnaround_clocks,
  output mdio_pkg::res_t                res_nxt
);
  import mdio_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_PRE  = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_TA   = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t          phase;
    logic [CntW-1:0] cnt;
  } entry_t;

  phase_t            phase_r, phase_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              half_r, half_nxt;
  logic [ShiftW-1:0] oshift_r, oshift_nxt;
  logic [DataW-1:0]  ishift_r, ishift_nxt;
  logic              is_write_r, is_write_nxt;
  logic              mdc_r, mdc_nxt;
  logic              mdo_r, mdo_nxt;
  logic              dir_in_r, dir_in_nxt;
  logic [DataW-1:0]  last_read_r, last_read_nxt;

  function automatic entry_t enter_hdr(input logic wr);
    entry_t e;
    e.phase = PH_HDR;
    e.cnt   = wr ? CntW'(32) : CntW'(14);
    return e;
  endfunction

  function automatic entry_t enter_pre(input logic wr, input logic [PreLenW-1:0] len);
    entry_t          e;
    logic [CntW-1:0] n;
    n = (len >= PreLenW'(33)) ? CntW'(len - PreLenW'(33)) : CntW'(len);
    if (n != '0) begin
      e.phase = PH_PRE;
      e.cnt   = n;
    end else begin
      e = enter_hdr(wr);
    end
    return e;
  endfunction

  function automatic entry_t enter_ta(input logic [TaW-1:0] ta);
    entry_t e;
    if (ta != '0) begin
      e.phase = PH_TA;
      e.cnt   = CntW'(ta);
    end else begin
      e.phase = PH_DATA;
      e.cnt   = CntW'(16);
    end
    return e;
  endfunction

  always_comb begin
    entry_t          ent;
    logic [CntW-1:0] cnt_dec;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    half_nxt      = half_r;
    oshift_nxt    = oshift_r;
    ishift_nxt    = ishift_r;
    is_write_nxt  = is_write_r;
    mdc_nxt       = mdc_r;
    mdo_nxt       = mdo_r;
    dir_in_nxt    = dir_in_r;
    last_read_nxt = last_read_r;
    res_nxt.done_res = 1'b0;
    ent     = '{phase: PH_DATA, cnt: CntW'(16)};
    cnt_dec = (cnt_r != '0) ? cnt_r - CntW'(1) : cnt_r;

    if ((item.req_type == REQ_READ || item.req_type == REQ_WRITE) && phase_r == PH_IDLE) begin
      is_write_nxt = item.req_type[0];
      if (item.req_type[0]) begin
        oshift_nxt = {2'b01, 2'b01, item.phy_addr, item.reg_addr, 2'b10, item.write_data};
      end else begin
        oshift_nxt = {2'b01, 2'b10, item.phy_addr, item.reg_addr, 18'd0};
      end
      ishift_nxt = '0;
      half_nxt   = 1'b0;
      ent        = enter_pre(item.req_type[0], preamble_length);
      phase_nxt  = ent.phase;
      cnt_nxt    = ent.cnt;
    end else if (item.req_type == REQ_TICK && phase_r != PH_IDLE) begin
      if (!half_r) begin
        mdc_nxt  = 1'b0;
        half_nxt = 1'b1;
        if (phase_r == PH_PRE) begin
          mdo_nxt    = 1'b1;
          dir_in_nxt = 1'b0;
        end else if (phase_r == PH_HDR) begin
          mdo_nxt    = oshift_r[ShiftW-1];
          dir_in_nxt = 1'b0;
        end else begin
          mdo_nxt    = 1'b0;
          dir_in_nxt = 1'b1;
        end
      end else begin
        mdc_nxt  = 1'b1;
        half_nxt = 1'b0;
        if (phase_r == PH_DATA) begin
          ishift_nxt = {ishift_r[DataW-2:0], item.mdi_sample};
        end else if (phase_r == PH_HDR) begin
          oshift_nxt = {oshift_r[ShiftW-2:0], 1'b0};
        end
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          if (phase_r == PH_PRE) begin
            ent       = enter_hdr(is_write_r);
            phase_nxt = ent.phase;
            cnt_nxt   = ent.cnt;
          end else if (phase_r == PH_HDR && !is_write_r) begin
            ent       = enter_ta(read_turnaround_clocks);
            phase_nxt = ent.phase;
            cnt_nxt   = ent.cnt;
          end else if (phase_r == PH_TA) begin
            phase_nxt = PH_DATA;
            cnt_nxt   = CntW'(16);
          end else begin
            if (phase_r == PH_DATA) begin
              last_read_nxt = ishift_nxt;
            end
            phase_nxt        = PH_IDLE;
            mdc_nxt          = 1'b1;
            mdo_nxt          = 1'b0;
            dir_in_nxt       = 1'b1;
            res_nxt.done_res = 1'b1;
          end
        end
      end
    end

    res_nxt.mdc_level  = mdc_nxt;
    res_nxt.mdo_level  = mdo_nxt;
    res_nxt.input_mode = dir_in_nxt;
    res_nxt.busy_res   = (phase_nxt != PH_IDLE);
    res_nxt.read_data  = last_read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      half_r      <= 1'b0;
      oshift_r    <= '0;
      ishift_r    <= '0;
      is_write_r  <= 1'b0;
      mdc_r       <= 1'b1;
      mdo_r       <= 1'b0;
      dir_in_r    <= 1'b1;
      last_read_r <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      half_r      <= half_nxt;
      oshift_r    <= oshift_nxt;
      ishift_r    <= ishift_nxt;
      is_write_r  <= is_write_nxt;
      mdc_r       <= mdc_nxt;
      mdo_r       <= mdo_nxt;
      dir_in_r    <= dir_in_nxt;
      last_read_r <= last_read_nxt;
    end
  end

endmodule

### src/mdio_management_frame_master_unit.sv
// top level: stream handshake, input and result registers, configuration registers
//
// Clause-22 MDIO management master driven by a stream of items. A read or write
// request loads a frame while idle (requests while busy are ignored), and each
// half-period tick item moves MDC/MDO by half a clock period; every item returns
// exactly one result beat with the line levels, the busy flag, the data of the last
// completed read and tlast on the beat that finishes a frame. The block takes one
// item per cycle; the result beat is offered in the cycle after the clock edge that
// moves the item out of the input register into the result register, and the input
// stalls only while a result waits for out_tready. Configuration writes (index 0
// preamble length, index 1 read turnaround clocks) are taken in any cycle and must
// be made only while no beat is in flight; a new preamble length applies from the
// next request, a new turnaround from the next turnaround.
module mdio_management_frame_master_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // phy_addr[4:0], reg_addr[9:5], write_data[25:10], mdi_sample[26], zero fill
  input  logic [mdio_pkg::InTdataW-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mdc_level[0], mdo_level[1], input_mode[2], busy_res[3], read_data[19:4],
  // zero fill
  output logic [mdio_pkg::OutTdataW-1:0]  out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdio_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mdio_pkg::CfgDataW-1:0]   cfg_data
);
  import mdio_pkg::*;

  logic                 s1_valid_r;
  in_item_t             s1_item_r;
  logic                 out_valid_r;
  res_t                 out_res_r;
  res_t                 res_nxt;
  logic                 advance;
  logic [PreLenW-1:0]   pre_len_r;
  logic [TaW-1:0]       ta_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.req_type   <= in_tuser;
      s1_item_r.phy_addr   <= in_tdata[4:0];
      s1_item_r.reg_addr   <= in_tdata[9:5];
      s1_item_r.write_data <= in_tdata[25:10];
      s1_item_r.mdi_sample <= in_tdata[26];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_len_r <= PreLenReset;
      ta_r      <= TaReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PREAMBLE_LENGTH: pre_len_r <= cfg_data[PreLenW-1:0];
        CFG_READ_TURNAROUND: ta_r      <= cfg_data[TaW-1:0];
        default: ;
      endcase
    end
  end

  mdio_frame_core u_core (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .step_en                (advance),
    .item                   (s1_item_r),
    .preamble_length        (pre_len_r),
    .read_turnaround_clocks (ta_r),
    .res_nxt                (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.read_data, out_res_r.busy_res,
                       out_res_r.input_mode, out_res_r.mdo_level, out_res_r.mdc_level};
  assign out_tlast  = out_res_r.done_res;

endmodule

### tb/testbench.sv
// testbench for the mdio management frame master: directed frames, config edges, random traffic
`timescale 1ns / 100ps

module testbench;
  import mdio_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_HDR,
    ST_TA,
    ST_DATA
  } stage_t;

  typedef enum int {
    MDI_ZEROS,
    MDI_ONES,
    MDI_RANDOM
  } mdi_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata   = '0;
  logic [1:0]           in_tuser   = REQ_NONE;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index  = CFG_PREAMBLE_LENGTH;
  logic [CfgDataW-1:0]  cfg_data   = '0;

  // line state tracked alongside the block
  stage_t           stage    = ST_IDLE;
  logic [CntW-1:0]  bit_cnt  = '0;
  logic             half     = 1'b0;
  logic [31:0]      oshift   = '0;
  logic [15:0]      ishift   = '0;
  logic             wr       = 1'b0;
  logic             mdc      = 1'b1;
  logic             mdo      = 1'b0;
  logic             din      = 1'b1;
  logic [15:0]      last_rd  = '0;
  logic [5:0]       pre_len  = PreLenReset;
  logic [1:0]       ta_clks  = TaReset;

  res_t line_q[$];
  int   errors       = 0;
  int   items_sent   = 0;
  int   frames_done  = 0;
  int   reads_loaded = 0;
  int   writes_loaded = 0;
  bit   no_idle      = 1'b0;

  mdio_management_frame_master_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 37);
  end

  function automatic void enter_stage(stage_t s);
    logic [5:0] n;
    stage_t     nxt;
    nxt = s;
    if (nxt == ST_PRE) begin
      n = pre_len;
      if (n >= 6'd33) n = n - 6'd33;
      if (n != 0) begin
        stage   = ST_PRE;
        bit_cnt = n;
        return;
      end
      nxt = ST_HDR;
    end
    if (nxt == ST_HDR) begin
      stage   = ST_HDR;
      bit_cnt = wr ? 6'd32 : 6'd14;
      return;
    end
    if (nxt == ST_TA && ta_clks != 0) begin
      stage   = ST_TA;
      bit_cnt = {4'b0, ta_clks};
      return;
    end
    stage   = ST_DATA;
    bit_cnt = 6'd16;
  endfunction

  function automatic res_t line_predict(in_item_t it);
    res_t r;
    logic fin;
    fin = 1'b0;
    if ((it.req_type == REQ_READ || it.req_type == REQ_WRITE) && stage == ST_IDLE) begin
      wr = (it.req_type == REQ_WRITE);
      if (wr) begin
        oshift = {2'b01, 2'b01, it.phy_addr, it.reg_addr, 2'b10, it.write_data};
        writes_loaded++;
      end else begin
        oshift = {2'b01, 2'b10, it.phy_addr, it.reg_addr, 18'd0};
        reads_loaded++;
      end
      ishift = '0;
      half   = 1'b0;
      enter_stage(ST_PRE);
    end else if (it.req_type == REQ_TICK && stage != ST_IDLE) begin
      if (!half) begin
        mdc = 1'b0;
        if (stage == ST_PRE) begin
          mdo = 1'b1;
          din = 1'b0;
        end else if (stage == ST_HDR) begin
          mdo = oshift[31];
          din = 1'b0;
        end else begin
          mdo = 1'b0;
          din = 1'b1;
        end
        half = 1'b1;
      end else begin
        mdc  = 1'b1;
        half = 1'b0;
        if (stage == ST_DATA) ishift = {ishift[14:0], it.mdi_sample};
        else if (stage == ST_HDR) oshift = oshift << 1;
        if (bit_cnt != 0) bit_cnt = bit_cnt - 6'd1;
        if (bit_cnt == 0) begin
          if (stage == ST_PRE) begin
            enter_stage(ST_HDR);
          end else if (stage == ST_HDR && !wr) begin
            enter_stage(ST_TA);
          end else if (stage == ST_TA) begin
            enter_stage(ST_DATA);
          end else begin
            if (stage == ST_DATA) last_rd = ishift;
            stage = ST_IDLE;
            mdc   = 1'b1;
            mdo   = 1'b0;
            din   = 1'b1;
            fin   = 1'b1;
          end
        end
      end
    end
    r.mdc_level  = mdc;
    r.mdo_level  = mdo;
    r.input_mode = din;
    r.busy_res   = (stage != ST_IDLE);
    r.done_res   = fin;
    r.read_data  = last_rd;
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] req, logic [4:0] phy, logic [4:0] rg,
                                         logic [15:0] wd, logic mdi);
    in_item_t it;
    it.req_type   = req;
    it.phy_addr   = phy;
    it.reg_addr   = rg;
    it.write_data = wd;
    it.mdi_sample = mdi;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {5'b0, it.mdi_sample, it.write_data, it.reg_addr, it.phy_addr};
    do @(posedge clk); while (!in_tready);
    line_q.push_back(line_predict(it));
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (line_q.size() != 0);
  endtask

  task automatic set_config(input logic [5:0] pre, input logic [1:0] ta);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PREAMBLE_LENGTH;
    cfg_data  <= pre;
    do @(posedge clk); while (!cfg_ready);
    pre_len = pre;
    cfg_index <= CFG_READ_TURNAROUND;
    cfg_data  <= {4'b0, ta};
    do @(posedge clk); while (!cfg_ready);
    ta_clks = ta;
    cfg_valid <= 1'b0;
  endtask

  task automatic idle_noise();
    logic [1:0] req;
    req = ($urandom_range(1) != 0) ? REQ_TICK : REQ_NONE;
    send_item(make_item(req, 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom)));
  endtask

  // one full frame: the request, then ticks until the frame ends, with ignored items mixed in
  task automatic run_frame(input req_t kind, input logic [4:0] phy, input logic [4:0] rg,
                           input logic [15:0] wd, input mdi_mode_t mode, input int noise_pct);
    logic       mdi;
    logic [1:0] junk;
    send_item(make_item(kind, phy, rg, wd, 1'($urandom)));
    while (stage != ST_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0:       junk = REQ_READ;
          1:       junk = REQ_WRITE;
          default: junk = REQ_NONE;
        endcase
        send_item(make_item(junk, 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom)));
      end
      case (mode)
        MDI_ZEROS: mdi = 1'b0;
        MDI_ONES:  mdi = 1'b1;
        default:   mdi = 1'($urandom);
      endcase
      send_item(make_item(REQ_TICK, 5'($urandom), 5'($urandom), 16'($urandom), mdi));
    end
  endtask

  task automatic test_idle_items();
    send_item(make_item(REQ_TICK, 5'h1f, 5'h1f, 16'hffff, 1'b1));
    send_item(make_item(REQ_NONE, 5'h00, 5'h00, 16'h0000, 1'b0));
    send_item(make_item(REQ_NONE, 5'h1f, 5'h1f, 16'hffff, 1'b1));
    send_item(make_item(REQ_TICK, 5'h00, 5'h00, 16'h0000, 1'b0));
  endtask

  // reset preamble and turnaround, sent without any idle cycles
  task automatic test_default_frames();
    no_idle = 1'b1;
    run_frame(REQ_READ, 5'h1f, 5'h1f, 16'hffff, MDI_ONES, 0);
    no_idle = 1'b0;
  endtask

  task automatic test_busy_requests();
    set_config(6'd1, 2'd1);
    run_frame(REQ_WRITE, 5'h15, 5'h0a, 16'ha5a5, MDI_RANDOM, 30);
  endtask

  task automatic test_config_edges();
    set_config(6'd0, 2'd0);
    run_frame(REQ_READ, 5'h03, 5'h1c, 16'h0000, MDI_ZEROS, 0);
    set_config(6'd33, 2'd2);
    run_frame(REQ_READ, 5'h11, 5'h0e, 16'h0000, MDI_RANDOM, 0);
    set_config(6'd34, 2'd3);
    run_frame(REQ_READ, 5'h0e, 5'h11, 16'h0000, MDI_RANDOM, 0);
  endtask

  task automatic test_random_traffic();
    int         start_items;
    logic [5:0] pre;
    req_t       kind;
    case ($urandom_range(9))
      0, 1:    pre = 6'($urandom_range(63));
      2:       pre = PreLenReset;
      default: pre = 6'($urandom_range(4));
    endcase
    set_config(pre, 2'($urandom_range(3)));
    start_items = items_sent;
    while (items_sent - start_items < 60) begin
      while ($urandom_range(99) < 20) idle_noise();
      kind = ($urandom_range(1) != 0) ? REQ_WRITE : REQ_READ;
      run_frame(kind, 5'($urandom), 5'($urandom), 16'($urandom), MDI_RANDOM, 8);
    end
  endtask

  function automatic void cmp_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
    end
  endfunction

  always @(posedge clk) begin : line_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mdc_level  = out_tdata[0];
      got.mdo_level  = out_tdata[1];
      got.input_mode = out_tdata[2];
      got.busy_res   = out_tdata[3];
      got.done_res   = out_tlast;
      got.read_data  = out_tdata[19:4];
      if (line_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none pending, expected nothing, actual %h",
                 $time, out_tdata);
      end else begin
        want = line_q.pop_front();
        cmp_field("mdc_level", 32'(want.mdc_level), 32'(got.mdc_level));
        cmp_field("mdo_level", 32'(want.mdo_level), 32'(got.mdo_level));
        cmp_field("input_mode", 32'(want.input_mode), 32'(got.input_mode));
        cmp_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        cmp_field("done_res", 32'(want.done_res), 32'(got.done_res));
        cmp_field("read_data", 32'(want.read_data), 32'(got.read_data));
        if (got.done_res) frames_done++;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_items();
    test_default_frames();
    test_busy_requests();
    test_config_edges();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (line_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, line_q.size());
    end
    $display("ran %0d items: %0d reads and %0d writes loaded, %0d frames finished",
             items_sent, reads_loaded, writes_loaded, frames_done);
    $display("preamble 0, 1, 32, 33, 34 and one random, turnaround 0 to 3, busy and idle items");
    if (errors == 0) begin
      $display("[mdio_management_frame_master_unit] OK");
    end else begin
      $display("[mdio_management_frame_master_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[mdio_management_frame_master_unit] ERROR");
    $finish;
  end

endmodule
